// ----- src/acr_pkg.sv -----
// shared types for the bounding box accumulator
`default_nettype none

package acr_pkg;

  // request from the sequencer to the square root unit
  typedef struct packed {
    logic start;
  } acr_sqrt_req_t;

  // status from the square root unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } acr_sqrt_rsp_t;

endpackage

`default_nettype wire

// ----- src/acr_vtx_if.sv -----
// vertex channel interface: valid, ready and one vertex with its flags
`default_nettype none

interface acr_vtx_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;
  logic signed [COORD_BITS-1:0] z;
  logic                         first;
  logic                         last;

  modport source (output valid, output x, output y, output z, output first, output last,
                  input ready);
  modport sink (input valid, input x, input y, input z, input first, input last,
                output ready);
endinterface

`default_nettype wire

// ----- src/acr_box_if.sv -----
// result channel interface: valid, ready and the box, centre and radius
`default_nettype none

interface acr_box_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] low_x;
  logic signed [COORD_BITS-1:0] low_y;
  logic signed [COORD_BITS-1:0] low_z;
  logic signed [COORD_BITS-1:0] high_x;
  logic signed [COORD_BITS-1:0] high_y;
  logic signed [COORD_BITS-1:0] high_z;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-1:0] radius;

  modport source (output valid, output low_x, output low_y, output low_z,
                  output high_x, output high_y, output high_z,
                  output center_x, output center_y, output center_z,
                  output radius, input ready);
  modport sink (input valid, input low_x, input low_y, input low_z,
                input high_x, input high_y, input high_z,
                input center_x, input center_y, input center_z,
                input radius, output ready);
endinterface

`default_nettype wire

// ----- src/aabb_accumulate_center_radius.sv -----
// 3d bounding box accumulator with centre and radius, bit-serial datapath
//
// Vertices arrive on vtx_i and are taken when valid and ready are both high.
// A vertex with first set empties the box before it is merged; a vertex with
// last set produces one transfer on box_o after its merge: the box corners,
// the per-axis centre (min+max)>>1 and the radius isqrt(dx^2+dy^2+dz^2)>>1.
// Each vertex is merged LSB first, one bit per cycle, so ready drops after
// every transfer until the merge is done. A vertex with last goes on through
// a serial extent and centre pass, a shift-add sum of squares over the three
// axes, the start of the root unit, the root unit itself, a wait to see it
// finish and the load of the output register that raises box_o.valid; the
// next vertex can be taken once that load is done.
// The output register holds a finished result while the next vertices are
// merged; only a further last vertex waits there until box_o is free, so a
// stalled receiver holds up the input once a second result is ready.
// Reset leaves the box empty (min at the most positive value, max at the
// most negative) and no result pending.
`default_nettype none

module aabb_accumulate_center_radius #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  acr_vtx_if.sink    vtx_i,
  acr_box_if.source  box_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned R     = C + 1;
  localparam int unsigned SQ_W  = 2 * R;
  localparam int unsigned CNT_W = $clog2(C);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(C - 1);
  localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EXTENT,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         axis_q;
  logic               last_q;
  logic signed [C-1:0] v_q   [3];
  logic signed [C-1:0] min_q [3];
  logic signed [C-1:0] max_q [3];
  logic               lt_q  [3];
  logic               gt_q  [3];
  logic               cy_q  [3];
  logic               bw_q  [3];
  logic [C-1:0]       ctr_q [3];
  logic [C-1:0]       d_q   [3];
  logic [SQ_W-1:0]    acc_q;
  logic [SQ_W-1:0]    mcand_q;
  logic [C-1:0]       mult_q;
  logic               sqrt_start_q;

  logic               out_valid_q;
  logic signed [C-1:0] lo_q  [3];
  logic signed [C-1:0] hi_q  [3];
  logic signed [C-1:0] cen_q [3];
  logic [C-1:0]       rad_q;

  logic               msb;
  logic               lt_n    [3];
  logic               gt_n    [3];
  logic               sum_b   [3];
  logic               sum_top [3];
  logic               cy_n    [3];
  logic               dif_b   [3];
  logic               bw_n    [3];
  logic [C-1:0]       d_next0;
  logic [C-1:0]       d_sel;

  acr_pkg::acr_sqrt_req_t sqrt_req;
  acr_pkg::acr_sqrt_rsp_t sqrt_rsp;
  logic [R-1:0]           sqrt_root;

  function automatic logic [C-1:0] rot(input logic [C-1:0] w);
    return {w[0], w[C-1:1]};
  endfunction

  assign msb = (cnt_q == LAST_BIT);

  // per-lane serial compare, add and subtract on the current low bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb) begin
        lt_n[i] = (v_q[i][0] & ~min_q[i][0]) | (~(v_q[i][0] ^ min_q[i][0]) & lt_q[i]);
        gt_n[i] = (max_q[i][0] & ~v_q[i][0]) | (~(v_q[i][0] ^ max_q[i][0]) & gt_q[i]);
      end else begin
        lt_n[i] = (~v_q[i][0] & min_q[i][0]) | (~(v_q[i][0] ^ min_q[i][0]) & lt_q[i]);
        gt_n[i] = (~max_q[i][0] & v_q[i][0]) | (~(v_q[i][0] ^ max_q[i][0]) & gt_q[i]);
      end
      sum_b[i]   = min_q[i][0] ^ max_q[i][0] ^ cy_q[i];
      cy_n[i]    = (min_q[i][0] & max_q[i][0]) | (cy_q[i] & (min_q[i][0] ^ max_q[i][0]));
      sum_top[i] = min_q[i][0] ^ max_q[i][0] ^ cy_n[i];
      dif_b[i]   = max_q[i][0] ^ min_q[i][0] ^ bw_q[i];
      bw_n[i]    = (~max_q[i][0] & min_q[i][0]) | (~(max_q[i][0] ^ min_q[i][0]) & bw_q[i]);
    end
  end

  // extent of the first axis as it completes, and the next axis to square
  assign d_next0 = {dif_b[0], d_q[0][C-1:1]};
  assign d_sel   = (axis_q == 2'd0) ? d_q[1] : d_q[2];

  assign sqrt_req.start = sqrt_start_q;

  acr_isqrt #(
    .ROOT_BITS (R)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rad_i  (acc_q),
    .rsp_o  (sqrt_rsp),
    .root_o (sqrt_root)
  );

  // sequencer, box state, serial datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      axis_q       <= 2'd0;
      sqrt_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= CMAX;
        max_q[i] <= CMIN;
      end
    end else begin
      sqrt_start_q <= 1'b0;
      if (box_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (vtx_i.valid) begin
            v_q[0] <= vtx_i.x;
            v_q[1] <= vtx_i.y;
            v_q[2] <= vtx_i.z;
            last_q <= vtx_i.last;
            cnt_q  <= '0;
            for (int i = 0; i < 3; i++) begin
              lt_q[i] <= 1'b0;
              gt_q[i] <= 1'b0;
              if (vtx_i.first) begin
                min_q[i] <= CMAX;
                max_q[i] <= CMIN;
              end
            end
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          cnt_q <= cnt_q + 1'b1;
          for (int i = 0; i < 3; i++) begin
            lt_q[i] <= lt_n[i];
            gt_q[i] <= gt_n[i];
            v_q[i]  <= rot(v_q[i]);
            min_q[i] <= (msb && lt_n[i]) ? rot(v_q[i]) : rot(min_q[i]);
            max_q[i] <= (msb && gt_n[i]) ? rot(v_q[i]) : rot(max_q[i]);
          end
          if (msb) begin
            cnt_q <= '0;
            for (int i = 0; i < 3; i++) begin
              cy_q[i] <= 1'b0;
              bw_q[i] <= 1'b0;
            end
            state_q <= last_q ? ST_EXTENT : ST_IDLE;
          end
        end
        ST_EXTENT: begin
          cnt_q <= cnt_q + 1'b1;
          for (int i = 0; i < 3; i++) begin
            cy_q[i]  <= cy_n[i];
            bw_q[i]  <= bw_n[i];
            d_q[i]   <= {dif_b[i], d_q[i][C-1:1]};
            min_q[i] <= rot(min_q[i]);
            max_q[i] <= rot(max_q[i]);
            if (msb) begin
              ctr_q[i] <= {sum_top[i], sum_b[i], ctr_q[i][C-1:2]};
            end else if (cnt_q != '0) begin
              ctr_q[i] <= {sum_b[i], ctr_q[i][C-1:1]};
            end
          end
          if (msb) begin
            cnt_q   <= '0;
            axis_q  <= 2'd0;
            acc_q   <= '0;
            mcand_q <= {{(SQ_W-C){1'b0}}, d_next0};
            mult_q  <= d_next0;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          cnt_q   <= cnt_q + 1'b1;
          if (mult_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q <= {mcand_q[SQ_W-2:0], 1'b0};
          mult_q  <= {1'b0, mult_q[C-1:1]};
          if (msb) begin
            cnt_q <= '0;
            if (axis_q == 2'd2) begin
              sqrt_start_q <= 1'b1;
              state_q      <= ST_ROOT;
            end else begin
              axis_q  <= axis_q + 2'd1;
              mcand_q <= {{(SQ_W-C){1'b0}}, d_sel};
              mult_q  <= d_sel;
            end
          end
        end
        ST_ROOT: begin
          if (sqrt_rsp.done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || box_o.ready) begin
            for (int i = 0; i < 3; i++) begin
              lo_q[i]  <= min_q[i];
              hi_q[i]  <= max_q[i];
              cen_q[i] <= ctr_q[i];
            end
            rad_q       <= sqrt_root[R-1:1];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // channel signals
  assign vtx_i.ready    = (state_q == ST_IDLE);
  assign box_o.valid    = out_valid_q;
  assign box_o.low_x    = lo_q[0];
  assign box_o.low_y    = lo_q[1];
  assign box_o.low_z    = lo_q[2];
  assign box_o.high_x   = hi_q[0];
  assign box_o.high_y   = hi_q[1];
  assign box_o.high_z   = hi_q[2];
  assign box_o.center_x = cen_q[0];
  assign box_o.center_y = cen_q[1];
  assign box_o.center_z = cen_q[2];
  assign box_o.radius   = rad_q;

  // a transfer always starts a fresh merge pass
  a_accept_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_i.valid && vtx_i.ready) |=> (state_q == ST_MERGE) && (cnt_q == '0))
    else $error("merge pass did not start after vertex transfer");

  // the root unit reports completion only while the sequencer waits for it
  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_rsp.done |-> (state_q == ST_ROOT))
    else $error("square root finished outside the root phase");

  // the root unit is never restarted while still iterating
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_req.start |-> !sqrt_rsp.busy)
    else $error("square root started while busy");

  // a presented box is ordered and its centre lies inside it
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_o.valid |-> (box_o.low_x <= box_o.center_x) && (box_o.center_x <= box_o.high_x)
                 && (box_o.low_y <= box_o.center_y) && (box_o.center_y <= box_o.high_y)
                 && (box_o.low_z <= box_o.center_z) && (box_o.center_z <= box_o.high_z))
    else $error("result box out of order");

endmodule

`default_nettype wire

// ----- src/acr_isqrt.sv -----
// integer square root, digit recurrence, one root bit per cycle
`default_nettype none

module acr_isqrt #(
  parameter int unsigned ROOT_BITS = 25
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire acr_pkg::acr_sqrt_req_t      req_i,
  input  wire logic [2*ROOT_BITS-1:0]      rad_i,
  output acr_pkg::acr_sqrt_rsp_t           rsp_o,
  output logic      [ROOT_BITS-1:0]        root_o
);

  localparam int unsigned R    = ROOT_BITS;
  localparam int unsigned CW   = $clog2(R);
  localparam logic [CW-1:0] LAST = CW'(R - 1);

  logic [2*R-1:0] n_q;
  logic [R:0]     rem_q;
  logic [R-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;

  logic [R+1:0]   rem_sh;
  logic [R+1:0]   trial;
  logic           ge;

  // shift in the next pair of radicand bits and try the next root bit
  assign rem_sh = {rem_q[R-1:0], n_q[2*R-1:2*R-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        n_q    <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        n_q    <= {n_q[2*R-3:0], 2'b00};
        rem_q  <= ge ? rem_sh[R:0] - trial[R:0] : rem_sh[R:0];
        root_q <= {root_q[R-2:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign root_o     = root_q;

endmodule

`default_nettype wire

// ----- tb/aabb_accumulate_center_radius_test.sv -----
// self-checking testbench for the 3d bounding box accumulator with centre and radius

module aabb_accumulate_center_radius_test;

  localparam int CB             = 24;
  localparam int CMAX           = 2 ** (CB - 1) - 1;
  localparam int CMIN           = -(2 ** (CB - 1));
  localparam int N_FIELDS       = 10;
  localparam int SETTLE_CYCLES  = 6 * CB + 60;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 272;

  // slots of one box transfer, in port order
  typedef enum int {
    F_LOW_X, F_LOW_Y, F_LOW_Z,
    F_HIGH_X, F_HIGH_Y, F_HIGH_Z,
    F_CENTER_X, F_CENTER_Y, F_CENTER_Z,
    F_RADIUS
  } box_field_e;

  typedef logic [N_FIELDS-1:0][CB-1:0] box_word_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 first;
    logic                 last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  acr_vtx_if #(.COORD_BITS(CB)) vtx ();
  acr_box_if #(.COORD_BITS(CB)) box ();

  aabb_accumulate_center_radius #(.COORD_BITS(CB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .box_o  (box)
  );

  // predicted box and the boxes still owed by the block
  logic signed [CB-1:0] box_low  [3];
  logic signed [CB-1:0] box_high [3];
  box_word_t            box_expected [$];

  int fail_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;

  always #5 clk_i = ~clk_i;

  task automatic note_failure(input string what);
    if (fail_count < 10) $display("[%0t] box check: %s", $time, what);
    fail_count++;
  endtask

  task automatic empty_box();
    for (int a = 0; a < 3; a++) begin
      box_low[a]  = CB'(CMAX);
      box_high[a] = CB'(CMIN);
    end
  endtask

  // floor of the square root, one result bit per step from the top
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // merge one vertex into the box, owe a transfer when it closes the set
  task automatic merge_vertex(input vertex_t v);
    logic signed [CB-1:0] coord [3];
    logic        [CB:0]   pair_sum;
    longint               extent;
    longint unsigned      diag_sq;
    box_word_t            result;
    coord[0] = v.x;
    coord[1] = v.y;
    coord[2] = v.z;
    if (v.first) empty_box();
    for (int a = 0; a < 3; a++) begin
      if (coord[a] < box_low[a])  box_low[a]  = coord[a];
      if (coord[a] > box_high[a]) box_high[a] = coord[a];
    end
    if (v.last) begin
      diag_sq = 0;
      for (int a = 0; a < 3; a++) begin
        // sign-extended sum, floor halving drops the low bit
        pair_sum = {box_high[a][CB-1], box_high[a]} + {box_low[a][CB-1], box_low[a]};
        result[F_LOW_X + a]    = box_low[a];
        result[F_HIGH_X + a]   = box_high[a];
        result[F_CENTER_X + a] = pair_sum[CB:1];
        extent  = longint'(box_high[a]) - longint'(box_low[a]);
        diag_sq += longint'(extent * extent);
      end
      result[F_RADIUS] = CB'(root_floor(diag_sq) >> 1);
      box_expected.push_back(result);
    end
  endtask

  // offer one vertex, with an optional gap first, until it is taken
  task automatic send_vertex(input vertex_t v);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 3 * CB);
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.x     <= v.x;
    vtx.y     <= v.y;
    vtx.z     <= v.z;
    vtx.first <= v.first;
    vtx.last  <= v.last;
    do @(posedge clk_i); while (vtx.ready !== 1'b1);
    merge_vertex(v);
  endtask

  // sender stands still until every owed box has been taken
  task automatic wait_for_results();
    @(negedge clk_i);
    vtx.valid <= 1'b0;
    while (box_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic vertex_t vertex_at(input int x, input int y, input int z,
                                        input bit first, input bit last);
    vertex_t v;
    v.x     = CB'(x);
    v.y     = CB'(y);
    v.z     = CB'(z);
    v.first = first;
    v.last  = last;
    return v;
  endfunction

  // coordinates biased towards the extremes and towards zero
  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return CB'(CMAX);
      1:       return CB'(CMIN);
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return CB'($urandom_range(0, 200) - 100);
      default: return CB'($urandom());
    endcase
  endfunction

  // either a free vertex or one close to the set's anchor point
  function automatic vertex_t pick_vertex(input bit tight, input vertex_t anchor);
    vertex_t v;
    v = '0;
    if (tight) begin
      v.x = anchor.x + CB'($urandom_range(0, 511) - 256);
      v.y = anchor.y + CB'($urandom_range(0, 511) - 256);
      v.z = anchor.z + CB'($urandom_range(0, 511) - 256);
    end else begin
      v.x = rand_coord();
      v.y = rand_coord();
      v.z = rand_coord();
    end
    return v;
  endfunction

  // extremes, merging without a first, one-point boxes and floor halving
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_vertex(vertex_at(5, -3, 7, 1'b0, 1'b1));
    send_vertex(vertex_at(-10, 20, -30, 1'b0, 1'b1));
    send_vertex(vertex_at(CMAX, CMAX, CMAX, 1'b1, 1'b1));
    send_vertex(vertex_at(CMIN, CMIN, CMIN, 1'b1, 1'b1));
    send_vertex(vertex_at(0, 0, 0, 1'b1, 1'b1));
    send_vertex(vertex_at(-1, -1, -1, 1'b1, 1'b1));
    send_vertex(vertex_at(CMIN, CMIN, CMIN, 1'b1, 1'b0));
    send_vertex(vertex_at(CMAX, CMAX, CMAX, 1'b0, 1'b1));
    send_vertex(vertex_at(CMIN, 0, CMAX, 1'b1, 1'b0));
    send_vertex(vertex_at(CMAX, -1, CMIN, 1'b0, 1'b0));
    send_vertex(vertex_at(3, -3, 0, 1'b0, 1'b1));
    send_vertex(vertex_at(-3, 0, -3, 1'b1, 1'b0));
    send_vertex(vertex_at(0, -3, 0, 1'b0, 1'b1));
    send_vertex(vertex_at(1, 2, 3, 1'b1, 1'b0));
    send_vertex(vertex_at(4, 6, 15, 1'b0, 1'b0));
    send_vertex(vertex_at(-2, -2, -2, 1'b0, 1'b1));
    send_vertex(vertex_at(100, 100, 100, 1'b1, 1'b0));
    send_vertex(vertex_at(7, 8, 9, 1'b1, 1'b1));
    send_vertex(vertex_at(CMAX, CMIN, 0, 1'b0, 1'b1));
    send_vertex(vertex_at(5592405, -5592406, 5592405, 1'b1, 1'b0));
    send_vertex(vertex_at(-5592406, 5592405, -5592406, 1'b0, 1'b1));
    wait_for_results();
  endtask

  // mostly well-formed sets with random content, some stray and broken ones
  task automatic test_random_sets(input int n_items, input int src_pct, input int sink_pct);
    int      sent;
    int      set_len;
    bit      tight;
    bit      drop_first;
    bit      drop_last;
    vertex_t anchor;
    vertex_t v;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        v       = pick_vertex(1'b0, '0);
        v.first = $urandom_range(0, 1);
        v.last  = $urandom_range(0, 1);
        send_vertex(v);
        sent++;
      end else begin
        set_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, CB) : $urandom_range(1, 6);
        tight      = $urandom_range(0, 1);
        drop_first = ($urandom_range(0, 9) == 0);
        drop_last  = ($urandom_range(0, 9) == 0);
        anchor     = pick_vertex(1'b0, '0);
        for (int k = 0; k < set_len; k++) begin
          v       = pick_vertex(tight, anchor);
          v.first = (k == 0) && !drop_first;
          v.last  = (k == set_len - 1) && !drop_last;
          send_vertex(v);
        end
        sent += set_len;
      end
    end
    wait_for_results();
  endtask

  // receiver holds off while short sets keep coming, so the input backs up
  task automatic test_stalled_receiver();
    vertex_t v;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 40; k++) begin
      v       = pick_vertex(1'b0, '0);
      v.first = ($urandom_range(0, 2) != 0);
      v.last  = ($urandom_range(0, 2) != 0);
      send_vertex(v);
    end
    wait_for_results();
  endtask

  // receiver readiness: random stalls plus requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_left = HOLD_LEN;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      box.ready <= 1'b0;
    end else begin
      box.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // compare each box transfer with the oldest owed box
  always @(posedge clk_i) begin : check_box
    box_word_t  seen;
    box_word_t  want;
    box_field_e fld;
    if (rst_ni && box.valid === 1'b1 && box.ready === 1'b1) begin
      seen[F_LOW_X]    = box.low_x;
      seen[F_LOW_Y]    = box.low_y;
      seen[F_LOW_Z]    = box.low_z;
      seen[F_HIGH_X]   = box.high_x;
      seen[F_HIGH_Y]   = box.high_y;
      seen[F_HIGH_Z]   = box.high_z;
      seen[F_CENTER_X] = box.center_x;
      seen[F_CENTER_Y] = box.center_y;
      seen[F_CENTER_Z] = box.center_z;
      seen[F_RADIUS]   = box.radius;
      if (box_expected.size() == 0) begin
        note_failure("box transfer with no box owed");
      end else begin
        want = box_expected.pop_front();
        for (int i = 0; i < N_FIELDS; i++) begin
          if (seen[i] !== want[i]) begin
            fld = box_field_e'(i);
            note_failure($sformatf("%s expected %06h got %06h", fld.name(), want[i], seen[i]));
          end
        end
      end
    end
  end

  // ends the run when neither channel has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((vtx.valid === 1'b1 && vtx.ready === 1'b1) ||
          (box.valid === 1'b1 && box.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    vtx.valid      = 1'b0;
    vtx.x          = '0;
    vtx.y          = '0;
    vtx.z          = '0;
    vtx.first      = 1'b0;
    vtx.last       = 1'b0;
    box.ready      = 1'b0;
    fail_count     = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    empty_box();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_sets(PHASE_ITEMS, 0, 0);
    test_random_sets(PHASE_ITEMS, 46, 0);
    test_stalled_receiver();
    test_random_sets(PHASE_ITEMS, 0, 46);
    test_random_sets(PHASE_ITEMS, 25, 25);

    // let any late or stray transfer show up before judging
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && box_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
